// ===== sv/mrbp_pkg.sv =====
package mrbp_pkg;

    localparam int VALUE_BYTES = 4;

    localparam logic [7:0] PREAMBLE       = 8'hFE;
    localparam logic [4:0] VALUE_POS      = 5'd15;
    localparam logic [4:0] VALUE_END      = VALUE_POS + 5'(VALUE_BYTES);
    localparam logic [4:0] UNIT_POS       = 5'd19;
    localparam logic [7:0] UNIT_M3        = 8'h2C;
    localparam logic [7:0] UNIT_TENTH     = 8'h2B;
    localparam logic [7:0] UNIT_HUNDREDTH = 8'h2A;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       last_in_reply;
    } t_in_word;

    typedef struct packed {
        logic [27:0] flow_hundredths;
        logic [7:0]  unit_code;
        logic        unit_known;
    } t_out_word;

    typedef struct packed {
        logic [31:0] value_bytes;
        logic [7:0]  unit_code;
    } t_job;

    typedef enum logic [1:0] {
        SCALE_ONE,
        SCALE_TENTH,
        SCALE_HUNDREDTH
    } t_scale;

    function automatic logic [7:0] bcd_pair(input logic [7:0] b);
        logic [7:0] hi;
        hi = {4'd0, b[7:4]};
        return 8'((hi << 3) + (hi << 1) + {4'd0, b[3:0]});
    endfunction

endpackage

// ===== sv/mrbp_front.sv =====
module mrbp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  mrbp_pkg::t_in_word  i_word,
    output logic                o_job_push,
    output mrbp_pkg::t_job      o_job
);

    logic        r_prev_was_preamble, n_prev_was_preamble;
    logic        r_in_frame, n_in_frame;
    logic [4:0]  r_byte_position, n_byte_position;
    logic [31:0] r_value_bytes, n_value_bytes;
    logic [4:0]  byte_offset;

    always_comb begin
        n_prev_was_preamble = r_prev_was_preamble;
        n_in_frame          = r_in_frame;
        n_byte_position     = r_byte_position;
        n_value_bytes       = r_value_bytes;
        o_job_push          = 1'b0;
        o_job.value_bytes   = r_value_bytes;
        o_job.unit_code     = i_word.rx_byte;
        byte_offset         = 5'd0;
        if (i_accept) begin
            if (!r_in_frame) begin
                if (r_prev_was_preamble && i_word.rx_byte != mrbp_pkg::PREAMBLE) begin
                    n_in_frame      = 1'b1;
                    n_byte_position = 5'd1;
                    n_value_bytes   = 32'd0;
                end
                n_prev_was_preamble = (i_word.rx_byte == mrbp_pkg::PREAMBLE);
            end else begin
                n_byte_position = r_byte_position + 5'd1;
                byte_offset     = n_byte_position - mrbp_pkg::VALUE_POS;
                if (n_byte_position >= mrbp_pkg::VALUE_POS &&
                    n_byte_position < mrbp_pkg::VALUE_END) begin
                    for (int b = 0; b < 4; b++) begin
                        if (byte_offset[1:0] == 2'(b)) begin
                            n_value_bytes[8*b +: 8] = i_word.rx_byte;
                        end
                    end
                end
                if (n_byte_position == mrbp_pkg::UNIT_POS) begin
                    o_job_push          = 1'b1;
                    n_prev_was_preamble = 1'b0;
                    n_in_frame          = 1'b0;
                    n_byte_position     = 5'd0;
                    n_value_bytes       = 32'd0;
                end
            end
            if (i_word.last_in_reply) begin
                n_prev_was_preamble = 1'b0;
                n_in_frame          = 1'b0;
                n_byte_position     = 5'd0;
                n_value_bytes       = 32'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_was_preamble <= 1'b0;
            r_in_frame          <= 1'b0;
            r_byte_position     <= 5'd0;
            r_value_bytes       <= 32'd0;
        end else begin
            r_prev_was_preamble <= n_prev_was_preamble;
            r_in_frame          <= n_in_frame;
            r_byte_position     <= n_byte_position;
            r_value_bytes       <= n_value_bytes;
        end
    end

endmodule

// ===== sv/mrbp_jobq.sv =====
module mrbp_jobq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mrbp_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output mrbp_pkg::t_job o_job,
    output logic           o_empty
);

    mrbp_pkg::t_job                r_mem [mrbp_pkg::QUEUE_DEPTH];
    logic [mrbp_pkg::QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [mrbp_pkg::QUEUE_AW:0]   r_count;
    logic                          do_push, do_pop;

    assign o_full  = (r_count == (mrbp_pkg::QUEUE_AW+1)'(mrbp_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!do_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== sv/mrbp_back.sv =====
module mrbp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_empty,
    input  mrbp_pkg::t_job      i_job,
    output logic                o_job_pop,
    output logic                o_empty,
    input  logic                i_pop,
    output mrbp_pkg::t_out_word o_word
);

    localparam logic [31:0] MAGIC_TENTH     = 32'hCCCCCCCD;
    localparam logic [31:0] MAGIC_HUNDREDTH = 32'h51EB851F;

    logic                 advance;
    logic                 r_v1, r_v2, r_v3, r_v4;
    logic [14:0]          r1_lo, r1_hi;
    mrbp_pkg::t_scale     r1_scale, r2_scale, r3_scale;
    logic [7:0]           r1_code, r2_code, r3_code;
    logic                 r1_known, r2_known, r3_known;
    logic [27:0]          r2_v, r3_v;
    logic [59:0]          r3_prod;
    mrbp_pkg::t_out_word  r4_word;
    mrbp_pkg::t_scale     job_scale;
    logic                 job_known;
    logic [27:0]          rounded;
    logic [31:0]          magic;
    logic [27:0]          quotient;

    mrbp_pkg::t_out_word               r_mem [mrbp_pkg::QUEUE_DEPTH];
    logic [mrbp_pkg::QUEUE_AW-1:0]     r_wr_ptr, r_rd_ptr;
    logic [mrbp_pkg::QUEUE_AW:0]       r_count;
    logic                              out_full, out_push, out_pop;

    assign out_full  = (r_count == (mrbp_pkg::QUEUE_AW+1)'(mrbp_pkg::QUEUE_DEPTH));
    assign advance   = !out_full;
    assign o_job_pop = advance && !i_job_empty;
    assign out_push  = advance && r_v4;
    assign o_empty   = (r_count == '0);
    assign out_pop   = i_pop && !o_empty;
    assign o_word    = r_mem[r_rd_ptr];

    always_comb begin
        job_scale = mrbp_pkg::SCALE_ONE;
        job_known = 1'b0;
        case (i_job.unit_code)
            mrbp_pkg::UNIT_M3: begin
                job_known = 1'b1;
            end
            mrbp_pkg::UNIT_TENTH: begin
                job_scale = mrbp_pkg::SCALE_TENTH;
                job_known = 1'b1;
            end
            mrbp_pkg::UNIT_HUNDREDTH: begin
                job_scale = mrbp_pkg::SCALE_HUNDREDTH;
                job_known = 1'b1;
            end
            default: begin
                job_scale = mrbp_pkg::SCALE_ONE;
            end
        endcase
    end

    always_comb begin
        rounded = r2_v;
        magic   = MAGIC_TENTH;
        case (r2_scale)
            mrbp_pkg::SCALE_TENTH: begin
                rounded = r2_v + 28'd5;
                magic   = MAGIC_TENTH;
            end
            mrbp_pkg::SCALE_HUNDREDTH: begin
                rounded = r2_v + 28'd50;
                magic   = MAGIC_HUNDREDTH;
            end
            default: begin
                rounded = r2_v;
            end
        endcase
    end

    always_comb begin
        case (r3_scale)
            mrbp_pkg::SCALE_TENTH:     quotient = 28'(r3_prod >> 35);
            mrbp_pkg::SCALE_HUNDREDTH: quotient = 28'(r3_prod >> 37);
            default:                   quotient = r3_v;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r1_lo    <= 15'(15'(mrbp_pkg::bcd_pair(i_job.value_bytes[15:8])) * 15'd100
                        + 15'(mrbp_pkg::bcd_pair(i_job.value_bytes[7:0])));
            r1_hi    <= 15'(15'(mrbp_pkg::bcd_pair(i_job.value_bytes[31:24])) * 15'd100
                        + 15'(mrbp_pkg::bcd_pair(i_job.value_bytes[23:16])));
            r1_scale <= job_scale;
            r1_code  <= i_job.unit_code;
            r1_known <= job_known;

            r2_v     <= 28'(28'(r1_hi) * 28'd10000 + 28'(r1_lo));
            r2_scale <= r1_scale;
            r2_code  <= r1_code;
            r2_known <= r1_known;

            r3_v     <= r2_v;
            r3_prod  <= 60'(rounded) * 60'(magic);
            r3_scale <= r2_scale;
            r3_code  <= r2_code;
            r3_known <= r2_known;

            r4_word.flow_hundredths <= quotient;
            r4_word.unit_code       <= r3_code;
            r4_word.unit_known      <= r3_known;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (advance) begin
            r_v1 <= o_job_pop;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_push) begin
            r_mem[r_wr_ptr] <= r4_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (out_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (out_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (out_push && !out_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!out_push && out_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== sv/meter_reply_bcd_reading_parser.sv =====
// Parses meter reply bytes, one word per clock, and returns the packed BCD flow reading
// in hundredths of a cubic meter together with its unit code. A word is taken every
// cycle while full is low; a reading goes from its unit byte through a four-word job
// queue and the four-stage conversion pipeline to the result side.
// Full rises only when results are left unpopped long enough to fill both queues.
module meter_reply_bcd_reading_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  mrbp_pkg::t_in_word  i_word,
    output logic                empty,
    input  logic                pop,
    output mrbp_pkg::t_out_word o_word
);

    logic           accept;
    logic           job_push, job_pop, job_empty;
    mrbp_pkg::t_job front_job, queued_job;

    assign accept = push && !full;

    mrbp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_word     (i_word),
        .o_job_push (job_push),
        .o_job      (front_job)
    );

    mrbp_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (job_pop),
        .o_job   (queued_job),
        .o_empty (job_empty)
    );

    mrbp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (queued_job),
        .o_job_pop   (job_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_word      (o_word)
    );

endmodule
